[rtl/mlfq_tick_scheduler_defines.svh]
`ifndef MLFQ_TICK_SCHEDULER_DEFINES_SVH
`define MLFQ_TICK_SCHEDULER_DEFINES_SVH

// checks sampled on clk, muted while rst_n is low
`define MLFQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checks that must also hold while reset is applied
`define MLFQ_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/mlfq_pkg.sv]
`default_nettype none

package mlfq_pkg;

    localparam int ID_W       = 4;
    localparam int BURST_W    = 16;
    localparam int QTM_W      = 8;
    localparam int NL_W       = 3;
    localparam int NUM_QREGS  = 4;
    localparam int LVL_OUT_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_LEVELS = 3'd0,
        CFG_QUANTUM0   = 3'd1,
        CFG_QUANTUM1   = 3'd2,
        CFG_QUANTUM2   = 3'd3,
        CFG_QUANTUM3   = 3'd4
    } cfg_idx_t;

    localparam logic FUNC_ARRIVAL = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    localparam logic [NL_W-1:0] NUM_LEVELS_RESET = 3'd3;
    localparam logic [NUM_QREGS-1:0][QTM_W-1:0] QUANTUM_RESET =
        {8'd16, 8'd8, 8'd4, 8'd2};

    typedef logic [LVL_OUT_W-1:0] level_t;

    typedef struct packed {
        logic                func;
        logic [ID_W-1:0]     proc_id;
        logic [BURST_W-1:0]  burst;
    } in_word_t;

    typedef struct packed {
        logic                idle;
        logic [ID_W-1:0]     running_id;
        level_t              run_level;
        logic                finished;
        logic                demoted;
    } res_word_t;

    typedef struct packed {
        logic [NL_W-1:0]                   num_levels;
        logic [NUM_QREGS-1:0][QTM_W-1:0]   quantum;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/mlfq_if.sv]
`default_nettype none

interface mlfq_in_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [mlfq_pkg::ID_W-1:0]     proc_id;
    logic [mlfq_pkg::BURST_W-1:0]  burst;

    modport source (output valid, output func, output proc_id, output burst, input ready);
    modport sink   (input valid, input func, input proc_id, input burst, output ready);
endinterface

interface mlfq_res_if;
    logic                          valid;
    logic                          ready;
    logic                          idle;
    logic [mlfq_pkg::ID_W-1:0]     running_id;
    mlfq_pkg::level_t              run_level;
    logic                          finished;
    logic                          demoted;

    modport source (output valid, output idle, output running_id, output run_level,
                    output finished, output demoted, input ready);
    modport sink   (input valid, input idle, input running_id, input run_level,
                    input finished, input demoted, output ready);
endinterface

`default_nettype wire

[rtl/mlfq_tick_scheduler.sv]
// result: a tick word that is taken is held in the input register, and its result word is registered
//   in the output register when it executes, later only while a waiting result word is stalled; arrivals give none
// throughput: one word per cycle while no tick waits on a stalled result word; the level pick and
//   queue update are done combinationally on the registered input word
// reset: queue pointers, counts, quantum counters and remaining times clear to zero,
//   levels return to 3 with quanta 2, 4, 8, 16; queue storage is not cleared
`default_nettype none

module mlfq_tick_scheduler #(
    parameter int MAX_PROCS  = 16,
    parameter int MAX_LEVELS = 4
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [mlfq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mlfq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    mlfq_in_if.sink                                item,
    mlfq_res_if.source                             result
);

    mlfq_pkg::cfg_t      cfg;
    mlfq_pkg::in_word_t  in_word_reg;
    mlfq_pkg::res_word_t res_word;
    mlfq_pkg::res_word_t out_word_reg;
    logic                in_valid_reg;
    logic                in_valid_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                exec;
    logic                take;

    mlfq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mlfq_core #(
        .MAX_PROCS  (MAX_PROCS),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .exec  (exec),
        .word  (in_word_reg),
        .cfg   (cfg),
        .res   (res_word)
    );

    // arrivals need no result slot
    assign exec = in_valid_reg
                  && ((in_word_reg.func == mlfq_pkg::FUNC_ARRIVAL) || !out_valid_reg
                      || result.ready);
    assign item.ready = !in_valid_reg || exec;
    assign take       = item.valid && item.ready;

    always_comb
    begin
        in_valid_next  = take ? 1'b1 : (exec ? 1'b0 : in_valid_reg);
        out_valid_next = out_valid_reg && !result.ready;
        if (exec && (in_word_reg.func == mlfq_pkg::FUNC_TICK))
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_word_reg.func    <= item.func;
            in_word_reg.proc_id <= item.proc_id;
            in_word_reg.burst   <= item.burst;
        end
        if (exec && (in_word_reg.func == mlfq_pkg::FUNC_TICK))
        begin
            out_word_reg <= res_word;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.idle       = out_word_reg.idle;
    assign result.running_id = out_word_reg.running_id;
    assign result.run_level  = out_word_reg.run_level;
    assign result.finished   = out_word_reg.finished;
    assign result.demoted    = out_word_reg.demoted;

endmodule

`default_nettype wire

[rtl/mlfq_cfg.sv]
`default_nettype none

module mlfq_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [mlfq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mlfq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output mlfq_pkg::cfg_t                         cfg
);

    mlfq_pkg::cfg_t cfg_reg;
    mlfq_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                mlfq_pkg::CFG_NUM_LEVELS:
                    cfg_next.num_levels = cfg_wdata[mlfq_pkg::NL_W-1:0];
                mlfq_pkg::CFG_QUANTUM0:
                    cfg_next.quantum[0] = cfg_wdata[mlfq_pkg::QTM_W-1:0];
                mlfq_pkg::CFG_QUANTUM1:
                    cfg_next.quantum[1] = cfg_wdata[mlfq_pkg::QTM_W-1:0];
                mlfq_pkg::CFG_QUANTUM2:
                    cfg_next.quantum[2] = cfg_wdata[mlfq_pkg::QTM_W-1:0];
                mlfq_pkg::CFG_QUANTUM3:
                    cfg_next.quantum[3] = cfg_wdata[mlfq_pkg::QTM_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_levels <= mlfq_pkg::NUM_LEVELS_RESET;
            cfg_reg.quantum    <= mlfq_pkg::QUANTUM_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/mlfq_core.sv]
`default_nettype none

module mlfq_core #(
    parameter int MAX_PROCS  = 16,
    parameter int MAX_LEVELS = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                exec,
    input  wire mlfq_pkg::in_word_t  word,
    input  wire mlfq_pkg::cfg_t      cfg,
    output mlfq_pkg::res_word_t      res
);

    localparam int IDW   = mlfq_pkg::ID_W;
    localparam int BW    = mlfq_pkg::BURST_W;
    localparam int QW    = mlfq_pkg::QTM_W;
    localparam int PW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW    = $clog2(MAX_PROCS + 1);
    localparam int LW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int REM_N = (MAX_PROCS < (1 << IDW)) ? MAX_PROCS : (1 << IDW);
    localparam int RW    = (REM_N > 1) ? $clog2(REM_N) : 1;
    localparam logic [PW-1:0] PTR_LAST = PW'(MAX_PROCS - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(MAX_PROCS);

    logic [IDW-1:0] fifo_mem_reg [MAX_LEVELS][MAX_PROCS];
    logic [PW-1:0]  head_reg [MAX_LEVELS];
    logic [PW-1:0]  head_next [MAX_LEVELS];
    logic [PW-1:0]  tail_reg [MAX_LEVELS];
    logic [PW-1:0]  tail_next [MAX_LEVELS];
    logic [CW-1:0]  cnt_reg [MAX_LEVELS];
    logic [CW-1:0]  cnt_next [MAX_LEVELS];
    logic [QW-1:0]  qu_reg [MAX_LEVELS];
    logic [QW-1:0]  qu_next [MAX_LEVELS];
    logic [BW-1:0]  rem_reg [REM_N];
    logic [BW-1:0]  rem_next [REM_N];

    logic           en [MAX_LEVELS];
    logic [IDW-1:0] head_id [MAX_LEVELS];
    logic [QW-1:0]  qlim [MAX_LEVELS];
    logic           can_dem [MAX_LEVELS];
    logic           push_l [MAX_LEVELS];

    logic           found;
    logic [LW-1:0]  lv;
    logic [IDW-1:0] id;
    logic [BW-1:0]  rem_cur;
    logic [QW-1:0]  qu_inc;
    logic           left_zero;
    logic           expire;
    logic           is_tick;
    logic           is_arr;
    logic           serve;
    logic           fin;
    logic           dem;
    logic [IDW-1:0] push_id;

    for (genvar l = 0; l < MAX_LEVELS; l++)
    begin : g_level
        assign en[l]      = (l == 0) || (l < int'(cfg.num_levels));
        assign head_id[l] = fifo_mem_reg[l][head_reg[l]];
        assign qlim[l]    = cfg.quantum[(l < mlfq_pkg::NUM_QREGS) ? l : mlfq_pkg::NUM_QREGS - 1];
        if (l + 1 < MAX_LEVELS)
        begin : g_dem
            assign can_dem[l] = en[l + 1] && (cnt_reg[l + 1] != CNT_FULL);
        end
        else
        begin : g_last
            assign can_dem[l] = 1'b0;
        end
    end

    // lowest enabled non-empty level wins
    always_comb
    begin
        found = 1'b0;
        lv    = '0;
        for (int l = MAX_LEVELS - 1; l >= 0; l--)
        begin
            if (en[l] && (cnt_reg[l] != '0))
            begin
                found = 1'b1;
                lv    = LW'(l);
            end
        end
    end

    assign id        = head_id[lv];
    assign rem_cur   = rem_reg[id[RW-1:0]];
    assign left_zero = (rem_cur <= BW'(1));
    assign qu_inc    = QW'(qu_reg[lv] + 1'b1);
    assign expire    = (qu_inc == qlim[lv]);

    assign is_tick = exec && (word.func == mlfq_pkg::FUNC_TICK);
    assign is_arr  = exec && (word.func == mlfq_pkg::FUNC_ARRIVAL) && (word.burst != '0)
                     && (int'(word.proc_id) < MAX_PROCS) && (cnt_reg[0] != CNT_FULL);
    assign serve   = is_tick && found;
    assign fin     = left_zero;
    assign dem     = !left_zero && expire && can_dem[lv];
    assign push_id = is_arr ? word.proc_id : id;

    always_comb
    begin
        for (int l = 0; l < MAX_LEVELS; l++)
        begin
            logic pop;
            pop = serve && (int'(lv) == l) && (fin || dem);
            push_l[l] = ((l == 0) && is_arr)
                        || ((l > 0) && serve && dem && (int'(lv) == l - 1));
            head_next[l] = head_reg[l];
            tail_next[l] = tail_reg[l];
            cnt_next[l]  = cnt_reg[l];
            qu_next[l]   = qu_reg[l];
            if (pop)
            begin
                head_next[l] = (head_reg[l] == PTR_LAST) ? '0 : PW'(head_reg[l] + 1'b1);
            end
            if (push_l[l])
            begin
                tail_next[l] = (tail_reg[l] == PTR_LAST) ? '0 : PW'(tail_reg[l] + 1'b1);
            end
            if (push_l[l] && !pop)
            begin
                cnt_next[l] = CW'(cnt_reg[l] + 1'b1);
            end
            else if (pop && !push_l[l])
            begin
                cnt_next[l] = CW'(cnt_reg[l] - 1'b1);
            end
            if (serve && (int'(lv) == l))
            begin
                qu_next[l] = (fin || expire) ? '0 : qu_inc;
            end
        end
    end

    always_comb
    begin
        for (int p = 0; p < REM_N; p++)
        begin
            rem_next[p] = rem_reg[p];
            if (is_arr && (int'(word.proc_id) == p))
            begin
                rem_next[p] = word.burst;
            end
            else if (serve && (rem_cur != '0) && (int'(id[RW-1:0]) == p))
            begin
                rem_next[p] = BW'(rem_cur - 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < MAX_LEVELS; l++)
            begin
                head_reg[l] <= '0;
                tail_reg[l] <= '0;
                cnt_reg[l]  <= '0;
                qu_reg[l]   <= '0;
            end
            for (int p = 0; p < REM_N; p++)
            begin
                rem_reg[p] <= '0;
            end
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
            qu_reg   <= qu_next;
            rem_reg  <= rem_next;
        end
    end

    // queue storage, only entries already written are ever used
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < MAX_LEVELS; l++)
        begin
            if (push_l[l])
            begin
                fifo_mem_reg[l][tail_reg[l]] <= push_id;
            end
        end
    end

    always_comb
    begin
        res.idle       = !found;
        res.running_id = found ? id : '0;
        res.run_level  = found ? mlfq_pkg::level_t'(lv) : '0;
        res.finished   = found && fin;
        res.demoted    = found && dem;
    end

endmodule

`default_nettype wire

[rtl/mlfq_checker.sv]
`default_nettype none

`include "mlfq_tick_scheduler_defines.svh"

module mlfq_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           res_valid,
    input wire logic                           res_ready,
    input wire logic                           res_idle,
    input wire logic [mlfq_pkg::ID_W-1:0]      res_running_id,
    input wire mlfq_pkg::level_t               res_run_level,
    input wire logic                           res_finished,
    input wire logic                           res_demoted
);

    // an idle word carries no process
    `MLFQ_ASSERT(a_idle_clean, res_valid && res_idle |-> (res_running_id == '0) && (res_run_level == '0) && !res_finished && !res_demoted, "idle word carries process fields")

    // a process cannot both finish and move down
    `MLFQ_ASSERT(a_fin_xor_dem, res_valid |-> !(res_finished && res_demoted), "finished and demoted together")

    `MLFQ_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_idle) && $stable(res_running_id) && $stable(res_run_level) && $stable(res_finished) && $stable(res_demoted), "stalled result word changed")

    `MLFQ_ASSERT_RST(a_reset_quiet, !rst_n |-> !res_valid, "result valid during reset")

endmodule

bind mlfq_tick_scheduler mlfq_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .res_idle       (result.idle),
    .res_running_id (result.running_id),
    .res_run_level  (result.run_level),
    .res_finished   (result.finished),
    .res_demoted    (result.demoted)
);

`default_nettype wire
